/* rtl/msd_pkg.sv */
// ----------------------------------------------------------------------------
// msd_pkg
// Types, constants and lookup functions shared by the display driver files.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int DIGITS        = 4;
  localparam int SLOT_W        = 3;
  localparam int VALUE_W       = 14;
  localparam int TIME_W        = 32;
  localparam int PERIOD_W      = 8;
  localparam int WORD_W        = 16;
  localparam int BITCNT_W      = 4;
  localparam int RECIP_W       = 25;
  localparam int RECIP_SHIFT   = 24;

  localparam logic [VALUE_W-1:0]  MAX_VALUE    = 14'd9999;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd4;
  localparam logic [SLOT_W-1:0]   SLOT_FIRST   = 3'd1;
  localparam logic [SLOT_W-1:0]   SLOT_LAST    = 3'(DIGITS);
  localparam logic [7:0]          SEL_FIRST    = 8'h08;
  localparam logic [BITCNT_W-1:0] BIT_LAST     = 4'(WORD_W - 1);

  typedef logic [WORD_W-1:0] word_t;

  // one word handed across the queue
  typedef struct packed {
    logic  vld;
    word_t word;
  } word_xfer_t;

  // ceil(2^24 / 10^exp): exact floor division for values up to 9999
  function automatic logic [RECIP_W-1:0] pow10_recip(input logic [2:0] exp);
    logic [RECIP_W-1:0] r;
    case (exp)
      3'd0:    r = 25'd16777216;
      3'd1:    r = 25'd1677722;
      3'd2:    r = 25'd167773;
      3'd3:    r = 25'd16778;
      // clamped values stay below 10^4, so that quotient is always zero
      3'd4:    r = 25'd0;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

  // segment pattern, bit 0 = segment a
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] s;
    case (digit)
      4'd0:    s = 8'd63;
      4'd1:    s = 8'd6;
      4'd2:    s = 8'd91;
      4'd3:    s = 8'd79;
      4'd4:    s = 8'd102;
      4'd5:    s = 8'd109;
      4'd6:    s = 8'd125;
      4'd7:    s = 8'd7;
      4'd8:    s = 8'd127;
      4'd9:    s = 8'd111;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/muxed_seven_segment_driver_unit.sv */
// A digit-slot item passes the slot stage register, the word queue and the shift register
// before its first serial bit is presented. One item per cycle is accepted while the word
// queue is not full; a digit slot yields 16 bit items, one per cycle while out_tready is high.
// Items that take no slot or the idle slot are consumed without results.
// Reset (rst_n low, synchronous): slot period 4 ms, last slot time 0, slot 1, queue empty.
// ----------------------------------------------------------------------------
// muxed_seven_segment_driver_unit
// Multiplexed four-digit seven-segment driver with serial shift-register output.
// ----------------------------------------------------------------------------
module muxed_seven_segment_driver_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] time_ms, [45:32] display_value, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] serial_bit, rest zero
  output logic        out_tlast,  // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // slot_period_ms
);

  msd_pkg::word_xfer_t push;
  msd_pkg::word_xfer_t head;
  logic                q_full;
  logic                pop;
  logic                serial_bit;

  assign cfg_ready = 1'b1;

  msd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .time_ms       (in_tdata[31:0]),
    .display_value (in_tdata[45:32]),
    .cfg_we        (cfg_valid),
    .cfg_period    (cfg_data),
    .q_full        (q_full),
    .push          (push)
  );

  msd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  msd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .serial_bit (serial_bit),
    .frame_last (out_tlast)
  );

  assign out_tdata = {7'd0, serial_bit};

endmodule

/* rtl/msd_front.sv */
// ----------------------------------------------------------------------------
// msd_front
// Slot timing and digit split: decides per item whether a slot is taken and
// builds the 16-bit select/segment word for digit slots.
// ----------------------------------------------------------------------------
module msd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [msd_pkg::TIME_W-1:0]    time_ms,
  input  logic [msd_pkg::VALUE_W-1:0]   display_value,
  input  logic                          cfg_we,
  input  logic [msd_pkg::PERIOD_W-1:0]  cfg_period,
  input  logic                          q_full,
  output msd_pkg::word_xfer_t           push
);

  logic [msd_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [msd_pkg::TIME_W-1:0]   last_time_r, last_time_nxt;
  logic [msd_pkg::SLOT_W-1:0]   slot_r, slot_nxt;

  logic                         s1_vld_r, s1_vld_nxt;
  logic [1:0]                   s1_pos_r;
  logic [13:0]                  s1_qhi_r;
  logic [9:0]                   s1_qup_r;

  logic                         accept;
  logic                         advance;
  logic [msd_pkg::TIME_W-1:0]   elapsed;
  logic                         take;
  logic                         emit;
  logic [1:0]                   pos;
  logic [msd_pkg::VALUE_W-1:0]  v_sat;
  logic [38:0]                  prod_hi;
  logic [38:0]                  prod_up;
  logic [13:0]                  digit_full;
  logic [3:0]                   digit;

  assign advance   = s1_vld_r && !q_full;
  assign in_tready = !s1_vld_r || !q_full;
  assign accept    = in_tvalid && in_tready;

  assign elapsed = time_ms - last_time_r;
  assign take    = elapsed >= {{(msd_pkg::TIME_W - msd_pkg::PERIOD_W){1'b0}}, period_r};
  assign emit    = take && (slot_r >= msd_pkg::SLOT_FIRST) && (slot_r <= msd_pkg::SLOT_LAST);
  assign pos     = 2'(slot_r - msd_pkg::SLOT_FIRST);

  // clamp, then divide by 10^(3-pos) and 10^(4-pos) via reciprocals
  assign v_sat   = (display_value > msd_pkg::MAX_VALUE) ? msd_pkg::MAX_VALUE : display_value;
  assign prod_hi = 39'(v_sat) * 39'(msd_pkg::pow10_recip(3'(3'd3 - {1'b0, pos})));
  assign prod_up = 39'(v_sat) * 39'(msd_pkg::pow10_recip(3'(3'd4 - {1'b0, pos})));

  always_comb begin
    period_nxt    = period_r;
    last_time_nxt = last_time_r;
    slot_nxt      = slot_r;
    s1_vld_nxt    = advance ? 1'b0 : s1_vld_r;
    if (cfg_we) begin
      period_nxt = cfg_period;
    end
    if (accept && take) begin
      last_time_nxt = time_ms;
      if (emit) begin
        slot_nxt   = slot_r + 3'd1;
        s1_vld_nxt = 1'b1;
      end else begin
        // idle slot: no word, back to the first digit
        slot_nxt = msd_pkg::SLOT_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= msd_pkg::PERIOD_RESET;
      last_time_r <= '0;
      slot_r      <= msd_pkg::SLOT_FIRST;
      s1_vld_r    <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      last_time_r <= last_time_nxt;
      slot_r      <= slot_nxt;
      s1_vld_r    <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_pos_r <= pos;
      s1_qhi_r <= prod_hi[msd_pkg::RECIP_SHIFT +: 14];
      s1_qup_r <= prod_up[msd_pkg::RECIP_SHIFT +: 10];
    end
  end

  // digit = floor(v/10^k) - 10*floor(v/10^(k+1))
  assign digit_full = s1_qhi_r - (14'(s1_qup_r) * 14'd10);
  assign digit      = digit_full[3:0];

  assign push.vld  = advance;
  assign push.word = {msd_pkg::SEL_FIRST >> s1_pos_r, msd_pkg::seg_code(digit)};

endmodule

/* rtl/msd_fifo.sv */
// ----------------------------------------------------------------------------
// msd_fifo
// Short word queue between slot timing and the serialiser.
// ----------------------------------------------------------------------------
module msd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msd_pkg::word_xfer_t push,
  output logic                full,
  input  logic                pop,
  output msd_pkg::word_xfer_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  msd_pkg::word_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_pop;

  assign full      = (count_r == DEPTH_C);
  assign head.vld  = (count_r != '0);
  assign head.word = mem_r[rd_ptr_r];
  assign do_pop    = pop && head.vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.vld) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push.vld, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.word;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.vld && full))
    else $error("word pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count beyond depth");
`endif

endmodule

/* rtl/msd_back.sv */
// ----------------------------------------------------------------------------
// msd_back
// Serialiser: shifts each queued word out MSB first, one bit per item.
// ----------------------------------------------------------------------------
module msd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  msd_pkg::word_xfer_t head,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                serial_bit,
  output logic                frame_last
);

  msd_pkg::word_t                shift_r, shift_nxt;
  logic [msd_pkg::BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          fire;
  logic                          at_last;

  assign fire    = busy_r && out_tready;
  assign at_last = (cnt_r == msd_pkg::BIT_LAST);
  assign pop     = head.vld && (!busy_r || (fire && at_last));

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    if (pop) begin
      shift_nxt = head.word;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (fire) begin
      // advance to the next bit, drop out after the sixteenth
      shift_nxt = {shift_r[msd_pkg::WORD_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + 1'b1;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign out_tvalid = busy_r;
  assign serial_bit = shift_r[msd_pkg::WORD_W-1];
  assign frame_last = at_last;

`ifndef SYNTHESIS
  a_no_early_end: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !at_last) |=> busy_r)
    else $error("frame ended before sixteenth bit");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && at_last && !head.vld) |=> !busy_r)
    else $error("serialiser busy with no word queued");
`endif

endmodule
